### sv/tlr_pkg.sv
`timescale 1ns / 1ps

package tlr_pkg;

    localparam int unsigned SCREEN_WIDTH  = 834;
    localparam int unsigned SCREEN_HEIGHT = 500;
    localparam int unsigned LEFT_MARGIN   = 100;
    localparam int unsigned TOP_MARGIN    = 100;

    localparam logic [5:0] VISIBLE_BPP = 6'd32;

    localparam int unsigned COORD_W  = 12;
    localparam int unsigned PIXEL_W  = 13;
    localparam int unsigned ADDR_W   = 27;
    localparam int unsigned CFG_W    = 14;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned S_DATA_W = 56;
    localparam int unsigned M_DATA_W = 56;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BPP      = 2'd3;

    localparam logic [13:0] STRIDE_RESET = 14'd3200;

    typedef struct packed {
        logic load;      // latch endpoints and thickness
        logic setup_a;   // deltas and direction flags
        logic setup_b;   // major axis, walk start, counters
        logic pixel;     // compute pixel, advance walk
        logic out_load;  // address and output register load
    } tlr_cmd_t;

    typedef struct packed {
        logic busy;
    } tlr_status_t;

endpackage

### sv/tlr_ctrl.sv
`timescale 1ns / 1ps

module tlr_ctrl
    import tlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_mode,
    output logic        s_tready,
    input  logic        m_tready,
    output logic        m_tvalid,
    input  tlr_status_t status,
    output tlr_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SETUP_A = 3'd1;
    localparam logic [2:0] ST_SETUP_B = 3'd2;
    localparam logic [2:0] ST_PIXEL   = 3'd3;
    localparam logic [2:0] ST_ADDR    = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       s_fire;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && s_mode == MODE_LOAD)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP_A;
                end
                else if (s_fire && status.busy)
                begin
                    state_next = ST_PIXEL;
                end
            end
            ST_SETUP_A:
            begin
                cmd.setup_a = 1'b1;
                state_next  = ST_SETUP_B;
            end
            ST_SETUP_B:
            begin
                cmd.setup_b = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_PIXEL:
            begin
                cmd.pixel  = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                // hold here while the previous result is still waiting
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

### sv/tlr_datapath.sv
`timescale 1ns / 1ps

module tlr_datapath
    import tlr_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tlr_cmd_t                    cmd,
    output tlr_status_t                 status,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic signed [COORD_W-1:0]   start_x,
    input  logic signed [COORD_W-1:0]   start_y,
    input  logic signed [COORD_W-1:0]   end_x,
    input  logic signed [COORD_W-1:0]   end_y,
    input  logic [2:0]                  half_thickness,
    output logic signed [PIXEL_W-1:0]   pixel_x,
    output logic signed [PIXEL_W-1:0]   pixel_y,
    output logic [ADDR_W-1:0]           byte_address,
    output logic                        visible,
    output logic                        last
);

    // configuration
    logic [11:0] x_off_reg;
    logic [11:0] y_off_reg;
    logic [13:0] stride_reg;
    logic [5:0]  bpp_reg;

    // line as loaded
    logic signed [COORD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [2:0]                t_reg;

    // setup results
    logic [11:0] adx_reg, ady_reg;
    logic        gx_reg, lx_reg, gy_reg, ly_reg;
    logic        x_major_reg;
    logic        minor_neg_reg;
    logic signed [COORD_W-1:0] bx_reg, by_reg;
    logic [11:0] len_reg;
    logic [12:0] two_d_reg, two_dm_reg;

    // walk state
    logic signed [3:0] ox_reg, oy_reg;
    logic [11:0]       i_reg;
    logic [12:0]       r_reg;
    logic [11:0]       q_reg;
    logic              busy_reg;

    // pixel stage
    logic signed [PIXEL_W-1:0] px_reg, py_reg;
    logic                      vis_reg, fin_reg;

    // output register
    logic signed [PIXEL_W-1:0] out_x_reg, out_y_reg;
    logic [ADDR_W-1:0]         out_addr_reg;
    logic                      out_vis_reg, out_last_reg;

    logic signed [12:0] dx, dy;
    logic               x_major, take_start;
    logic signed [3:0]  t_pos, t_neg;
    logic [13:0]        r_sum;
    logic               carry;
    logic [12:0]        r_next;
    logic signed [13:0] i_s, q_s, x_w, y_w;
    logic signed [PIXEL_W-1:0] px_next, py_next;
    logic               vis_next, fin_next;
    logic [13:0]        col, row;
    logic [27:0]        row_bytes;
    logic [27:0]        addr_sum;
    logic [ADDR_W-1:0]  addr_next;

    function automatic logic signed [12:0] end_x_ext(input logic signed [COORD_W-1:0] v);
        end_x_ext = {v[COORD_W-1], v};
    endfunction

    assign status.busy = busy_reg;

    assign dx = 13'(end_x_ext(ex_reg)) - 13'(end_x_ext(sx_reg));
    assign dy = 13'(end_x_ext(ey_reg)) - 13'(end_x_ext(sy_reg));

    assign x_major    = adx_reg > ady_reg;
    assign take_start = x_major ? gx_reg : gy_reg;

    assign t_pos = $signed({1'b0, t_reg});
    assign t_neg = -t_pos;

    // rounded minor offset kept as quotient and remainder against 2*len
    assign r_sum  = {1'b0, r_reg} + {1'b0, two_dm_reg};
    assign carry  = (r_sum >= {1'b0, two_d_reg}) && (two_dm_reg != 13'd0);
    assign r_next = carry ? 13'(r_sum - {1'b0, two_d_reg}) : r_sum[12:0];

    assign i_s = $signed({2'b00, i_reg});
    assign q_s = minor_neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
    assign x_w = {{2{bx_reg[COORD_W-1]}}, bx_reg} + {{10{ox_reg[3]}}, ox_reg}
                 + (x_major_reg ? i_s : q_s);
    assign y_w = {{2{by_reg[COORD_W-1]}}, by_reg} + {{10{oy_reg[3]}}, oy_reg}
                 + (x_major_reg ? q_s : i_s);
    assign px_next = x_w[PIXEL_W-1:0];
    assign py_next = y_w[PIXEL_W-1:0];

    assign vis_next = !px_next[PIXEL_W-1] && (px_next < PIXEL_W'(SCREEN_WIDTH))
                      && !py_next[PIXEL_W-1] && (py_next < PIXEL_W'(SCREEN_HEIGHT))
                      && (bpp_reg == VISIBLE_BPP);
    assign fin_next = (ox_reg == t_pos) && (oy_reg == t_pos) && (i_reg == len_reg);

    // only used when visible, so the coordinate is below 4096
    assign col       = 14'(px_reg[11:0]) + 14'(LEFT_MARGIN) + 14'(x_off_reg);
    assign row       = 14'(py_reg[11:0]) + 14'(TOP_MARGIN) + 14'(y_off_reg);
    assign row_bytes = row * stride_reg;
    assign addr_sum  = {12'd0, col, 2'b00} + row_bytes;
    assign addr_next = vis_reg ? addr_sum[ADDR_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_off_reg  <= '0;
            y_off_reg  <= '0;
            stride_reg <= STRIDE_RESET;
            bpp_reg    <= VISIBLE_BPP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_X_OFFSET: x_off_reg  <= cfg_data[11:0];
                CFG_Y_OFFSET: y_off_reg  <= cfg_data[11:0];
                CFG_STRIDE:   stride_reg <= cfg_data[13:0];
                CFG_BPP:      bpp_reg    <= cfg_data[5:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            busy_reg <= 1'b1;
        end
        else if (cmd.pixel && fin_next)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sx_reg <= start_x;
            sy_reg <= start_y;
            ex_reg <= end_x;
            ey_reg <= end_y;
            t_reg  <= half_thickness;
        end

        if (cmd.setup_a)
        begin
            adx_reg <= dx[12] ? 12'(-dx) : dx[11:0];
            ady_reg <= dy[12] ? 12'(-dy) : dy[11:0];
            gx_reg  <= !dx[12] && (dx != 13'sd0);
            lx_reg  <= dx[12];
            gy_reg  <= !dy[12] && (dy != 13'sd0);
            ly_reg  <= dy[12];
        end

        if (cmd.setup_b)
        begin
            x_major_reg   <= x_major;
            bx_reg        <= take_start ? sx_reg : ex_reg;
            by_reg        <= take_start ? sy_reg : ey_reg;
            minor_neg_reg <= x_major ? (take_start ? ly_reg : gy_reg)
                                     : (take_start ? lx_reg : gx_reg);
            len_reg       <= x_major ? adx_reg : ady_reg;
            two_d_reg     <= {(x_major ? adx_reg : ady_reg), 1'b0};
            two_dm_reg    <= {(x_major ? ady_reg : adx_reg), 1'b0};
            ox_reg        <= t_neg;
            oy_reg        <= t_neg;
            i_reg         <= '0;
            r_reg         <= {1'b0, (x_major ? adx_reg : ady_reg)};
            q_reg         <= '0;
        end

        if (cmd.pixel)
        begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            vis_reg <= vis_next;
            fin_reg <= fin_next;
            if (i_reg == len_reg)
            begin
                i_reg <= '0;
                r_reg <= {1'b0, len_reg};
                q_reg <= '0;
                if (oy_reg == t_pos)
                begin
                    oy_reg <= t_neg;
                    if (ox_reg == t_pos)
                    begin
                        ox_reg <= '0;
                        oy_reg <= '0;
                    end
                    else
                    begin
                        ox_reg <= ox_reg + 4'sd1;
                    end
                end
                else
                begin
                    oy_reg <= oy_reg + 4'sd1;
                end
            end
            else
            begin
                i_reg <= i_reg + 12'd1;
                r_reg <= r_next;
                q_reg <= q_reg + 12'(carry);
            end
        end

        if (cmd.out_load)
        begin
            out_x_reg    <= px_reg;
            out_y_reg    <= py_reg;
            out_addr_reg <= addr_next;
            out_vis_reg  <= vis_reg;
            out_last_reg <= fin_reg;
        end
    end

    assign pixel_x      = out_x_reg;
    assign pixel_y      = out_y_reg;
    assign byte_address = out_addr_reg;
    assign visible      = out_vis_reg;
    assign last         = out_last_reg;

endmodule

### sv/thick_line_rasterizer_core.sv
`timescale 1ns / 1ps

// Thick line rasterizer. A load transaction (s_tuser = 0) stores two endpoints
// and a half thickness T and runs states SETUP_A and SETUP_B before the next
// transaction is accepted. Each step transaction (s_tuser = 1) then produces
// one pixel: the line is drawn once for every offset (ox, oy) in -T..T, ox
// outer, walked along its major axis with the minor coordinate rounded to
// nearest. A step that yields a pixel is accepted, computes the pixel, then
// does the address multiply and output load, which waits while the previous
// pixel still waits on m_tready. A step with no line pending is dropped without
// leaving idle. The minor coordinate is tracked incrementally as a quotient
// and remainder, so no divider is needed. byte_address is zero for pixels not
// visible (off screen or bpp not 32); m_tlast marks the final pixel.
// A step is accepted while the previous pixel is still waiting on the output.

module thick_line_rasterizer_core
    import tlr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36],
    // half_thickness[50:48], zero fill above
    input  logic [S_DATA_W-1:0]   s_tdata,
    // mode[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_x[12:0], pixel_y[25:13], byte_address[52:26], zero fill above
    output logic [M_DATA_W-1:0]   m_tdata,
    // visible[0]
    output logic                  m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    tlr_cmd_t    cmd;
    tlr_status_t status;

    logic signed [PIXEL_W-1:0] pixel_x, pixel_y;
    logic [ADDR_W-1:0]         byte_address;

    tlr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_mode   (s_tuser),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    tlr_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start_x        (s_tdata[11:0]),
        .start_y        (s_tdata[23:12]),
        .end_x          (s_tdata[35:24]),
        .end_y          (s_tdata[47:36]),
        .half_thickness (s_tdata[50:48]),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .byte_address   (byte_address),
        .visible        (m_tuser),
        .last           (m_tlast)
    );

    assign m_tdata = {3'b000, byte_address, pixel_y, pixel_x};

`ifndef SYNTH
    // pixels not marked visible carry a zero address
    a_hidden_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[52:26] == '0)
        else $error("invisible pixel with nonzero address");

    // a load always runs the setup sequence before the next transaction
    a_load_setup: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == MODE_LOAD |=> !s_tready)
        else $error("transaction accepted during line setup");

    // a step with no line pending is dropped at once
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == MODE_STEP && !status.busy |=> s_tready)
        else $error("idle step started pixel work");
`endif

endmodule
